[hw/rtl/tkpm_pkg.sv]
// ----------------------------------------------------------------------------
// tkpm_pkg
// Shared widths and types of the top-k peak mean tracker.
// ----------------------------------------------------------------------------
package tkpm_pkg;

    // field widths
    localparam int SMP_W  = 16;     // signed q8.8 sample
    localparam int VAL_W  = 15;     // kept values are never negative
    localparam int SUM_W  = 22;     // running sum of kept values

    // item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef logic        [VAL_W-1:0] value_t;
    typedef logic signed [SMP_W-1:0] sample_t;
    typedef logic        [SUM_W-1:0] sum_t;

endpackage

[hw/rtl/tkpm_item_if.sv]
// ----------------------------------------------------------------------------
// tkpm_item_if
// Input channel: one word carries a command and a sample.
// ----------------------------------------------------------------------------
interface tkpm_item_if
    import tkpm_pkg::*;
;
    logic    valid;
    logic    ready;
    logic    cmd;
    sample_t sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

[hw/rtl/tkpm_result_if.sv]
// ----------------------------------------------------------------------------
// tkpm_result_if
// Output channel: one word per item with min, max, mean and insert flag.
// ----------------------------------------------------------------------------
interface tkpm_result_if
    import tkpm_pkg::*;
;
    logic   valid;
    logic   ready;
    value_t kept_min;
    value_t kept_max;
    value_t kept_mean;
    logic   inserted;

    modport source (output valid, output kept_min, output kept_max,
                    output kept_mean, output inserted, input ready);
    modport sink   (input valid, input kept_min, input kept_max,
                    input kept_mean, input inserted, output ready);
endinterface

[hw/rtl/tkpm_ram.sv]
// ----------------------------------------------------------------------------
// tkpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tkpm_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/top_k_peak_mean_tracker_top.sv]
// Flow: a clear, or a sample that stays out, goes from IDLE to WAIT; a sample
// that goes in walks the store upward, a new maximum through PUT, and then to
// WAIT, one store entry per cycle; WAIT registers the result once output is free.
// Throughput: one item at a time, the next word is taken the cycle after the
// result is registered, later while a stalled result still holds the output.
// Reset: asynchronous; valid bits, sum, min/max and control clear at once.
// ----------------------------------------------------------------------------
// top_k_peak_mean_tracker_top
// Keeps the KEEP_COUNT largest samples in ascending order in a RAM and
// reports min, max and truncated mean of the kept set after every item.
// ----------------------------------------------------------------------------
module top_k_peak_mean_tracker_top
    import tkpm_pkg::*;
#(
    parameter int KEEP_COUNT = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tkpm_item_if.sink     item,
    tkpm_result_if.source result
);

    localparam int AW = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam logic [AW-1:0] LAST  = AW'(KEEP_COUNT - 1);
    localparam logic [AW-1:0] FIRST = AW'((KEEP_COUNT > 1) ? 1 : 0);

    // mean by reciprocal multiplication, exact for every sum below 2^SUM_W
    localparam int RSH   = SUM_W + $clog2(KEEP_COUNT);
    localparam int RCP_W = SUM_W + 1;
    localparam int PRD_W = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << RSH) + 64'(KEEP_COUNT) - 64'd1) / 64'(KEEP_COUNT));

    // control states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_PUT  = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    logic [1:0]            state_reg,   state_next;
    logic [AW-1:0]         pos_reg,     pos_next;
    value_t                smp_reg,     smp_next;
    logic                  ins_reg,     ins_next;
    logic [KEEP_COUNT-1:0] valid_reg,   valid_next;
    value_t                min_reg,     min_next;
    value_t                max_reg,     max_next;
    sum_t                  sum_reg,     sum_next;
    logic                  out_valid_reg, out_valid_next;
    value_t                out_min_reg, out_min_next;
    value_t                out_max_reg, out_max_next;
    value_t                out_mean_reg, out_mean_next;
    logic                  out_ins_reg, out_ins_next;

    logic                  accept;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    value_t                wr_data;
    logic [AW-1:0]         rd_addr;
    value_t                rd_data;
    value_t                cur;
    logic [PRD_W-1:0]      mean_prod;

    // sorted store
    tkpm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (KEEP_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign item.ready      = (state_reg == ST_IDLE);
    assign accept          = item.valid && item.ready;
    assign result.valid    = out_valid_reg;
    assign result.kept_min = out_min_reg;
    assign result.kept_max = out_max_reg;
    assign result.kept_mean = out_mean_reg;
    assign result.inserted = out_ins_reg;

    // entries never written since the last clear read as zero
    assign cur = valid_reg[pos_reg] ? rd_data : '0;

    // truncated mean of the settled sum
    assign mean_prod = PRD_W'(sum_reg) * PRD_W'(RECIP);

    // walk control, store writes and output load
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        smp_next       = smp_reg;
        ins_next       = ins_reg;
        valid_next     = valid_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg - AW'(1);
        wr_data        = smp_reg;
        rd_addr        = pos_reg + AW'(1);
        out_valid_next = out_valid_reg && !result.ready;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        out_mean_next  = out_mean_reg;
        out_ins_next   = out_ins_reg;

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = FIRST;
                if (accept)
                begin
                    state_next = ST_WAIT;
                    ins_next   = 1'b0;
                    if (item.cmd == CMD_CLEAR)
                    begin
                        valid_next = '0;
                        sum_next   = '0;
                        min_next   = '0;
                        max_next   = '0;
                    end
                    else if (item.sample > $signed({1'b0, min_reg}))
                    begin
                        // evict the smallest entry, then find the new place
                        ins_next = 1'b1;
                        smp_next = item.sample[VAL_W-1:0];
                        sum_next = sum_reg + SUM_W'(item.sample[VAL_W-1:0])
                                   - SUM_W'(min_reg);
                        if (KEEP_COUNT > 1)
                        begin
                            pos_next   = FIRST;
                            state_next = ST_WALK;
                        end
                        else
                        begin
                            pos_next   = LAST;
                            state_next = ST_PUT;
                        end
                    end
                end
            end
            ST_WALK:
            begin
                wr_en = 1'b1;
                if (smp_reg > cur)
                begin
                    // shift the entry down, read the next one
                    wr_data = cur;
                    if (pos_reg == LAST)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        pos_next = pos_reg + AW'(1);
                    end
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_min_next   = min_reg;
                    out_max_next   = max_reg;
                    out_mean_next  = mean_prod[RSH +: VAL_W];
                    out_ins_next   = ins_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // mirror the end entries and mark written entries
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
            if (wr_addr == '0)
            begin
                min_next = wr_data;
            end
            if (wr_addr == LAST)
            begin
                max_next = wr_data;
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            ins_reg       <= 1'b0;
            valid_reg     <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            ins_reg       <= ins_next;
            valid_reg     <= valid_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        smp_reg      <= smp_next;
        out_min_reg  <= out_min_next;
        out_max_reg  <= out_max_next;
        out_mean_reg <= out_mean_next;
        out_ins_reg  <= out_ins_next;
    end

endmodule

[hw/rtl/tkpm_checker.sv]
// ----------------------------------------------------------------------------
// tkpm_checker
// Port-level checks on the result channel of the tracker.
// ----------------------------------------------------------------------------
module tkpm_checker
    import tkpm_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   res_valid,
    input logic   res_ready,
    input value_t kept_min,
    input value_t kept_max,
    input value_t kept_mean,
    input logic   inserted
);

    // a stalled word holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kept_min)
            && $stable(kept_max) && $stable(kept_mean) && $stable(inserted))
        else $error("result word changed while stalled");

    // the ends of the ascending store are in order
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> kept_min <= kept_max)
        else $error("kept minimum above kept maximum");

    // the mean lies between the end entries
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> kept_mean >= kept_min && kept_mean <= kept_max)
        else $error("kept mean outside the kept range");

    // an inserted sample is positive, so the maximum cannot be zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && inserted |-> kept_max != '0)
        else $error("insertion reported with zero maximum");

endmodule

bind top_k_peak_mean_tracker_top tkpm_checker u_tkpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .kept_min  (result.kept_min),
    .kept_max  (result.kept_max),
    .kept_mean (result.kept_mean),
    .inserted  (result.inserted)
);
